[design/cuhr_pkg.sv]
// ----------------------------------------------------------------------------
// cuhr_pkg - shared definitions for the CPU utilization history ring
// Field widths, op codes, payload structs and default sizes.
// ----------------------------------------------------------------------------
package cuhr_pkg;

	localparam int SLOT_W = 3;
	localparam int CNT_W  = 64;
	localparam int TIME_W = 64;
	localparam int HIDX_W = 6;
	localparam int LOAD_W = 7;
	localparam int PTR_W  = 6;
	localparam int FILL_W = 7;
	localparam int GEN_W  = 32;
	localparam int RLEN_W = 7;

	// shared adder: 100 * 64-bit busy delta needs 71 bits
	localparam int ALU_W = 72;

	localparam int CPUS_DEFAULT  = 8;
	localparam int DEPTH_DEFAULT = 64;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic [LOAD_W-1:0] PCT_FULL       = 7'd100;
	localparam logic [RLEN_W-1:0] RING_LEN_RESET = 7'd64;
	localparam logic [RLEN_W-1:0] RING_LEN_MIN   = 7'd2;

	typedef struct packed {
		logic              op;
		logic [SLOT_W-1:0] cpu_slot;
		logic [CNT_W-1:0]  total_count;
		logic [CNT_W-1:0]  idle_count;
		logic              end_of_row;
		logic [TIME_W-1:0] row_time;
		logic [HIDX_W-1:0] history_index;
	} req_item_t;

	typedef struct packed {
		logic [LOAD_W-1:0] load_percent;
		logic [TIME_W-1:0] entry_time;
		logic [PTR_W-1:0]  head_index;
		logic [PTR_W-1:0]  oldest_index;
		logic [FILL_W-1:0] fill_count;
		logic [GEN_W-1:0]  wrap_generation;
	} rsp_item_t;

endpackage

[design/cuhr_req_if.sv]
// ----------------------------------------------------------------------------
// cuhr_req_if - request channel of the CPU utilization history ring
// valid/ready handshake carrying one sample or read transaction.
// ----------------------------------------------------------------------------
interface cuhr_req_if;
	logic                 valid;
	logic                 ready;
	cuhr_pkg::req_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/cuhr_rsp_if.sv]
// ----------------------------------------------------------------------------
// cuhr_rsp_if - result channel of the CPU utilization history ring
// valid/ready handshake carrying one result transaction.
// ----------------------------------------------------------------------------
interface cuhr_rsp_if;
	logic                 valid;
	logic                 ready;
	cuhr_pkg::rsp_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/cpu_utilization_history_ring.sv]
// ----------------------------------------------------------------------------
// cpu_utilization_history_ring - per-CPU busy percent with history ring
// Turns cumulative total/idle counters into a busy percent per CPU slot,
// stages one value per slot and commits whole rows into an overwriting ring.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake         | transaction
//  ---------+-----+-------------------+-----------------------------------
//  req      | in  | valid/ready       | sample (op 0) or history read (op 1)
//  rsp      | out | valid/ready       | one result per request
//  cfg      | in  | cfg_we, no stall  | ring_length write, empties history
//
//  Sample: deltas, busy, multiply, divide, stage, commit on a row end, out.
//  Read: history read, out. A zero total delta or idle ahead of total skips
//  the divide. One 72-bit add/subtract unit does all percent arithmetic: three
//  deltas, two shift-adds for 100 * busy and seven restoring divide steps.
//  Next request is accepted once the result sits in the output register.
//  Result register holds while rsp is stalled; a finished item waits for it.
//  Reset zeroes previous counters (per-slot valid bits), staged row and ring
//  pointers; history memories hold garbage until written.
//
module cpu_utilization_history_ring #(
	parameter int CPUS  = cuhr_pkg::CPUS_DEFAULT,
	parameter int DEPTH = cuhr_pkg::DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	cuhr_req_if.sink                            req,
	cuhr_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [cuhr_pkg::RLEN_W-1:0]         cfg_wdata
);

	// index widths
	localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;   // slot address
	localparam int PW = $clog2(DEPTH);                    // ring row address
	localparam int LW = $clog2(DEPTH + 1);                // row count, up to DEPTH
	localparam int AW = cuhr_pkg::ALU_W;

	typedef logic [CPUS-1:0][cuhr_pkg::LOAD_W-1:0] row_t;

	// sequencer codes
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_TD     = 4'd1;
	localparam logic [3:0] ST_ID     = 4'd2;
	localparam logic [3:0] ST_BUSY   = 4'd3;
	localparam logic [3:0] ST_MUL1   = 4'd4;
	localparam logic [3:0] ST_MUL2   = 4'd5;
	localparam logic [3:0] ST_DIV    = 4'd6;
	localparam logic [3:0] ST_STAGE  = 4'd7;
	localparam logic [3:0] ST_COMMIT = 4'd8;
	localparam logic [3:0] ST_READ   = 4'd9;
	localparam logic [3:0] ST_OUT    = 4'd10;

	logic [3:0] state_q;

	// control state
	logic [PW-1:0]                    head_q;
	logic [PW-1:0]                    tail_q;
	logic [LW-1:0]                    rows_q;
	logic [cuhr_pkg::GEN_W-1:0]       gen_q;
	logic [cuhr_pkg::RLEN_W-1:0]      ring_len_q;
	row_t                             staged_q;
	logic [CPUS-1:0]                  prev_vld_q;
	logic                             rsp_valid_q;

	// transaction fields captured at accept
	logic [CW-1:0]                    slot_q;
	logic                             slot_ok_q;
	logic                             hidx_ok_q;
	logic [cuhr_pkg::CNT_W-1:0]       total_q;
	logic [cuhr_pkg::CNT_W-1:0]       idle_q;
	logic                             eor_q;
	logic [cuhr_pkg::TIME_W-1:0]      stamp_q;

	// datapath
	logic [cuhr_pkg::CNT_W-1:0]       td_q;
	logic [cuhr_pkg::CNT_W-1:0]       busy_q;
	logic [AW-1:0]                    acc_q;
	logic [2:0]                       k_q;
	logic [5:0]                       quo_q;
	logic [cuhr_pkg::LOAD_W-1:0]      pct_q;
	logic [cuhr_pkg::TIME_W-1:0]      etime_q;
	cuhr_pkg::rsp_item_t              rsp_data_q;

	// memories, registered reads
	logic [cuhr_pkg::CNT_W-1:0]       prev_total_mem [CPUS];
	logic [cuhr_pkg::CNT_W-1:0]       prev_idle_mem  [CPUS];
	row_t                             hist_load_mem  [DEPTH];
	logic [cuhr_pkg::TIME_W-1:0]      hist_time_mem  [DEPTH];
	logic [cuhr_pkg::CNT_W-1:0]       prev_total_rd_q;
	logic [cuhr_pkg::CNT_W-1:0]       prev_idle_rd_q;
	row_t                             hist_load_rd_q;
	logic [cuhr_pkg::TIME_W-1:0]      hist_time_rd_q;

	// handshake
	logic req_fire;
	logic out_load;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_load  = (state_q == ST_OUT) && (!rsp_valid_q || rsp.ready);

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// request addresses, zero-extended then cut to the array index width
	logic [CW+cuhr_pkg::SLOT_W-1:0]   slot_wide;
	logic [PW+cuhr_pkg::HIDX_W-1:0]   hidx_wide;
	logic [CW-1:0]                    slot_addr;
	logic [PW-1:0]                    hidx_addr;

	assign slot_wide = {{CW{1'b0}}, req.data.cpu_slot};
	assign hidx_wide = {{PW{1'b0}}, req.data.history_index};
	assign slot_addr = slot_wide[CW-1:0];
	assign hidx_addr = hidx_wide[PW-1:0];

	// ring length in force, clamped to [2, DEPTH]
	logic [LW-1:0] len;

	always_comb begin
		if (ring_len_q < cuhr_pkg::RING_LEN_MIN) begin
			len = LW'(cuhr_pkg::RING_LEN_MIN);
		end else if (32'(ring_len_q) > 32'(DEPTH)) begin
			len = LW'(DEPTH);
		end else begin
			len = LW'(ring_len_q);
		end
	end

	// next head on a commit
	logic [LW-1:0] head_inc;
	logic          head_wrap;

	assign head_inc  = LW'(head_q) + LW'(1);
	assign head_wrap = (head_inc >= len);

	// previous counters, zero until the slot has been sampled once
	logic [cuhr_pkg::CNT_W-1:0] prev_total_eff;
	logic [cuhr_pkg::CNT_W-1:0] prev_idle_eff;

	assign prev_total_eff = prev_vld_q[slot_q] ? prev_total_rd_q : '0;
	assign prev_idle_eff  = prev_vld_q[slot_q] ? prev_idle_rd_q  : '0;

	// shared add/subtract unit; top bit is carry (no borrow on subtract)
	logic [AW-1:0] alu_a;
	logic [AW-1:0] alu_b;
	logic          alu_sub;
	logic [AW:0]   alu_sum;
	logic          alu_ge;

	always_comb begin
		alu_a   = acc_q;
		alu_b   = AW'(td_q) << k_q;
		alu_sub = 1'b1;
		case (state_q)
			ST_TD: begin
				alu_a = AW'(total_q);
				alu_b = AW'(prev_total_eff);
			end
			ST_ID: begin
				alu_a = AW'(idle_q);
				alu_b = AW'(prev_idle_eff);
			end
			ST_BUSY: begin
				alu_a = AW'(td_q);
				alu_b = acc_q;
			end
			ST_MUL1: begin
				alu_a   = AW'(busy_q) << 6;
				alu_b   = AW'(busy_q) << 5;
				alu_sub = 1'b0;
			end
			ST_MUL2: begin
				alu_a   = acc_q;
				alu_b   = AW'(busy_q) << 2;
				alu_sub = 1'b0;
			end
			default: begin
				// divide step: remainder minus td << k
				alu_a = acc_q;
				alu_b = AW'(td_q) << k_q;
			end
		endcase
	end

	assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
	assign alu_ge  = alu_sum[AW];

	// ring status fitted to the result fields
	logic [PW+cuhr_pkg::PTR_W-1:0]  head_out;
	logic [PW+cuhr_pkg::PTR_W-1:0]  tail_out;
	logic [LW+cuhr_pkg::FILL_W-1:0] rows_out;

	assign head_out = {{cuhr_pkg::PTR_W{1'b0}}, head_q};
	assign tail_out = {{cuhr_pkg::PTR_W{1'b0}}, tail_q};
	assign rows_out = {{cuhr_pkg::FILL_W{1'b0}}, rows_q};

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			rows_q      <= '0;
			gen_q       <= '0;
			ring_len_q  <= cuhr_pkg::RING_LEN_RESET;
			staged_q    <= '0;
			prev_vld_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.data.op == cuhr_pkg::OP_READ) begin
							state_q <= ST_READ;
						end else if (32'(req.data.cpu_slot) < 32'(CPUS)) begin
							state_q <= ST_TD;
						end else begin
							// slot beyond the array: no compute, percent 0
							state_q <= ST_STAGE;
						end
					end
				end
				ST_TD: begin
					state_q <= ST_ID;
				end
				ST_ID: begin
					// both previous counters consumed; slot now has history
					prev_vld_q[slot_q] <= 1'b1;
					state_q <= ST_BUSY;
				end
				ST_BUSY: begin
					// zero total delta or idle ahead of total: no divide
					if (td_q == '0 || !alu_ge) begin
						state_q <= ST_STAGE;
					end else begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (k_q == 3'd0) begin
						state_q <= ST_STAGE;
					end
				end
				ST_STAGE: begin
					if (slot_ok_q) begin
						staged_q[slot_q] <= pct_q;
					end
					state_q <= eor_q ? ST_COMMIT : ST_OUT;
				end
				ST_COMMIT: begin
					if (head_wrap) begin
						head_q <= '0;
						gen_q  <= gen_q + 1'b1;
					end else begin
						head_q <= head_inc[PW-1:0];
					end
					if (rows_q >= len) begin
						tail_q <= head_wrap ? '0 : head_inc[PW-1:0];
					end else begin
						rows_q <= rows_q + 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_READ: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// length write empties the ring; the user must write it only while idle, the block does not enforce this
			if (cfg_we) begin
				ring_len_q <= cfg_wdata;
				head_q     <= '0;
				tail_q     <= '0;
				rows_q     <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					slot_q    <= slot_addr;
					slot_ok_q <= (32'(req.data.cpu_slot) < 32'(CPUS));
					hidx_ok_q <= (32'(req.data.history_index) < 32'(DEPTH));
					total_q   <= req.data.total_count;
					idle_q    <= req.data.idle_count;
					eor_q     <= (req.data.op == cuhr_pkg::OP_SAMPLE) && req.data.end_of_row;
					stamp_q   <= req.data.row_time;
					pct_q     <= '0;
					etime_q   <= '0;
				end
			end
			ST_TD: begin
				td_q <= alu_sum[cuhr_pkg::CNT_W-1:0];
			end
			ST_ID: begin
				acc_q <= AW'(alu_sum[cuhr_pkg::CNT_W-1:0]);
			end
			ST_BUSY: begin
				busy_q <= alu_sum[cuhr_pkg::CNT_W-1:0];
				if (td_q == '0) begin
					pct_q <= '0;
				end else if (!alu_ge) begin
					pct_q <= cuhr_pkg::PCT_FULL;
				end
			end
			ST_MUL1: begin
				acc_q <= alu_sum[AW-1:0];
			end
			ST_MUL2: begin
				acc_q <= alu_sum[AW-1:0];
				k_q   <= 3'd6;
				quo_q <= '0;
			end
			ST_DIV: begin
				if (alu_ge) begin
					acc_q <= alu_sum[AW-1:0];
				end
				quo_q <= {quo_q[4:0], alu_ge};
				k_q   <= k_q - 3'd1;
				if (k_q == 3'd0) begin
					pct_q <= {quo_q, alu_ge};
				end
			end
			ST_READ: begin
				pct_q   <= (hidx_ok_q && slot_ok_q) ? hist_load_rd_q[slot_q] : '0;
				etime_q <= hidx_ok_q ? hist_time_rd_q : '0;
			end
			ST_OUT: begin
				if (out_load) begin
					rsp_data_q.load_percent    <= pct_q;
					rsp_data_q.entry_time      <= etime_q;
					rsp_data_q.head_index      <= head_out[cuhr_pkg::PTR_W-1:0];
					rsp_data_q.oldest_index    <= tail_out[cuhr_pkg::PTR_W-1:0];
					rsp_data_q.fill_count      <= rows_out[cuhr_pkg::FILL_W-1:0];
					rsp_data_q.wrap_generation <= gen_q;
				end
			end
			default: begin
			end
		endcase
	end

	// previous counter memories
	always_ff @(posedge clk) begin
		if (req_fire) begin
			prev_total_rd_q <= prev_total_mem[slot_addr];
			prev_idle_rd_q  <= prev_idle_mem[slot_addr];
		end
		if (state_q == ST_TD) begin
			prev_total_mem[slot_q] <= total_q;
			prev_idle_mem[slot_q]  <= idle_q;
		end
	end

	// history memories: one row of per-slot values plus its timestamp
	always_ff @(posedge clk) begin
		if (req_fire) begin
			hist_load_rd_q <= hist_load_mem[hidx_addr];
			hist_time_rd_q <= hist_time_mem[hidx_addr];
		end
		if (state_q == ST_COMMIT) begin
			hist_load_mem[head_q] <= staged_q;
			hist_time_mem[head_q] <= stamp_q;
		end
	end

	// ring bookkeeping stays inside the length in force
	a_rows_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= len)
		else $error("fill count exceeds ring length");

	a_head_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(head_q) < len)
		else $error("head pointer beyond ring length");

	// tail only moves once the ring has filled
	a_tail_until_full: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q < len |-> tail_q == '0)
		else $error("tail moved before ring filled");

	// divide only runs on a nonzero divisor and ends in range
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> td_q != '0)
		else $error("divide step with zero total delta");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_data_q.load_percent <= cuhr_pkg::PCT_FULL)
		else $error("busy percent above 100");

endmodule
